FILE: hdl/mct_pkg.sv
// Shared constants, codes and types of the multi-channel tachometer.
package mct_pkg;

  localparam int CHANNELS = 4;
  localparam int HISTORY  = 5;

  localparam int CH_W    = 2;
  localparam int TIME_W  = 32;
  localparam int PPR_W   = 8;
  localparam int CNT_W   = $clog2(HISTORY + 1);
  localparam int PTR_W   = $clog2(HISTORY);
  localparam int ADDR_W  = $clog2(CHANNELS * HISTORY);
  localparam int RPM_W   = 20;
  localparam int FLAG_W  = 2;

  // Microseconds per minute and the width it needs.
  localparam int USEC_PER_MIN = 60000000;
  localparam int UPM_W        = 26;

  // Divisor is pulses per revolution times the interval; dividend is
  // microseconds per minute times the edge count.
  localparam int DEN_W  = PPR_W + TIME_W;
  localparam int NUM_W  = UPM_W + CNT_W;
  localparam int STEP_W = $clog2(NUM_W);

  localparam logic [PPR_W-1:0] PPR_RESET = PPR_W'(5);

  localparam logic [FLAG_W-1:0] FLAG_OK      = 2'd0;
  localparam logic [FLAG_W-1:0] FLAG_NO_EDGE = 2'd1;
  localparam logic [FLAG_W-1:0] FLAG_SAT     = 2'd2;

  // Result of a history lookup for one channel.
  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [TIME_W-1:0] last_time;
    logic [TIME_W-1:0] old_time;
  } hist_rd_t;

endpackage

FILE: hdl/mct_hist.sv
// Per-channel edge history: timestamp memory, write positions and full flags.
module mct_hist (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [mct_pkg::CH_W-1:0]      ch_i,
  input  logic                          rd_en_i,
  input  logic                          wr_en_i,
  input  logic [mct_pkg::TIME_W-1:0]    time_i,
  output mct_pkg::hist_rd_t             rd_o
);

  logic [mct_pkg::TIME_W-1:0] mem_q [mct_pkg::CHANNELS*mct_pkg::HISTORY];
  logic [mct_pkg::PTR_W-1:0]  wp_q  [mct_pkg::CHANNELS];
  logic [mct_pkg::CHANNELS-1:0] full_q;

  logic [mct_pkg::TIME_W-1:0] prev_q, old_q;
  logic [mct_pkg::PTR_W-1:0]  wp, last_idx, old_idx, wp_next;
  logic [mct_pkg::ADDR_W-1:0] base, prev_addr, old_addr, wr_addr;
  logic                       full;

  always_comb begin
    wp       = wp_q[ch_i];
    full     = full_q[ch_i];
    last_idx = (wp == '0) ? mct_pkg::PTR_W'(mct_pkg::HISTORY - 1) : wp - 1'b1;
    old_idx  = full ? wp : '0;
    wp_next  = (wp == mct_pkg::PTR_W'(mct_pkg::HISTORY - 1)) ? '0 : wp + 1'b1;
    base      = mct_pkg::ADDR_W'(ch_i) * mct_pkg::ADDR_W'(mct_pkg::HISTORY);
    prev_addr = base + mct_pkg::ADDR_W'(last_idx);
    old_addr  = base + mct_pkg::ADDR_W'(old_idx);
    wr_addr   = base + mct_pkg::ADDR_W'(wp);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr] <= time_i;
    end
    if (rd_en_i) begin
      prev_q <= mem_q[prev_addr];
      old_q  <= mem_q[old_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mct_pkg::CHANNELS; i++) begin
        wp_q[i] <= '0;
      end
      full_q <= '0;
    end else if (wr_en_i) begin
      wp_q[ch_i] <= wp_next;
      if (wp_next == '0) begin
        full_q[ch_i] <= 1'b1;
      end
    end
  end

  assign rd_o.count     = full ? mct_pkg::CNT_W'(mct_pkg::HISTORY) : mct_pkg::CNT_W'(wp);
  assign rd_o.last_time = prev_q;
  assign rd_o.old_time  = old_q;

endmodule

FILE: hdl/mct_rpm.sv
// Bit-serial speed unit: shift-add multiply for the divisor, then restoring division.
module mct_rpm (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [mct_pkg::CNT_W-1:0]   count_i,
  input  logic [mct_pkg::TIME_W-1:0]  interval_i,
  input  logic [mct_pkg::PPR_W-1:0]   ppr_i,
  output logic                        done_o,
  output logic [mct_pkg::RPM_W-1:0]   rpm_o,
  output logic                        sat_o
);

  typedef enum logic [3:0] {
    R_IDLE = 4'b0001,
    R_MUL  = 4'b0010,
    R_DIV  = 4'b0100,
    R_FIN  = 4'b1000
  } rpm_state_e;

  rpm_state_e state_q, state_d;
  logic [mct_pkg::STEP_W-1:0] step_q, step_d;

  logic [mct_pkg::DEN_W-1:0] mcand_q, acc_q, rem_q;
  logic [mct_pkg::PPR_W-1:0] mplier_q;
  logic [mct_pkg::NUM_W-1:0] num_q, quo_q;

  logic [mct_pkg::DEN_W:0]   trial, diff;
  logic                      fits;

  always_comb begin
    trial = {rem_q, num_q[mct_pkg::NUM_W-1]};
    diff  = trial - {1'b0, acc_q};
    fits  = trial >= {1'b0, acc_q};
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      R_IDLE: begin
        if (start_i) begin
          state_d = R_MUL;
          step_d  = '0;
        end
      end
      R_MUL: begin
        step_d = step_q + 1'b1;
        if (step_q == mct_pkg::STEP_W'(mct_pkg::PPR_W - 1)) begin
          state_d = R_DIV;
          step_d  = '0;
        end
      end
      R_DIV: begin
        step_d = step_q + 1'b1;
        if (step_q == mct_pkg::STEP_W'(mct_pkg::NUM_W - 1)) begin
          state_d = R_FIN;
          step_d  = '0;
        end
      end
      R_FIN: begin
        state_d = R_IDLE;
      end
      default: begin
        state_d = R_IDLE;
        step_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Datapath needs no reset: start loads all but quo_q, which division fills.
  always_ff @(posedge clk_i) begin
    case (state_q)
      R_IDLE: begin
        if (start_i) begin
          mcand_q  <= mct_pkg::DEN_W'(interval_i);
          mplier_q <= ppr_i;
          acc_q    <= '0;
          rem_q    <= '0;
          num_q    <= mct_pkg::NUM_W'(mct_pkg::USEC_PER_MIN)
                      * mct_pkg::NUM_W'(count_i);
        end
      end
      R_MUL: begin
        if (mplier_q[0]) begin
          acc_q <= acc_q + mcand_q;
        end
        mcand_q  <= {mcand_q[mct_pkg::DEN_W-2:0], 1'b0};
        mplier_q <= {1'b0, mplier_q[mct_pkg::PPR_W-1:1]};
      end
      R_DIV: begin
        rem_q <= fits ? diff[mct_pkg::DEN_W-1:0] : trial[mct_pkg::DEN_W-1:0];
        quo_q <= {quo_q[mct_pkg::NUM_W-2:0], fits};
        num_q <= {num_q[mct_pkg::NUM_W-2:0], 1'b0};
      end
      default: begin
      end
    endcase
  end

  // A zero divisor makes every quotient bit one, which lands in saturation.
  assign sat_o  = |quo_q[mct_pkg::NUM_W-1:mct_pkg::RPM_W];
  assign rpm_o  = sat_o ? '1 : quo_q[mct_pkg::RPM_W-1:0];
  assign done_o = (state_q == R_FIN);

endmodule

FILE: hdl/multi_channel_tachometer.sv
// An edge goes through the read, start and calculate states, then holds until the output
// register is free. Only one edge is in flight; the calculate state lasts until the bit-serial
// speed units finish (8 multiply steps and 29 division steps, the two speeds side by side).
// A new edge is taken while the previous result still waits in the output register.
// Reset is asynchronous, active low: all channels empty, pulses per revolution 5;
// the timestamp memory is not cleared; only an empty channel reads unwritten entries.
module multi_channel_tachometer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,    // pulses_per_rev
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] event_time
  input  logic [1:0]  s_axis_tuser,  // [1:0] channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,  // [2:0] samples_used, [34:3] out_time,
                                     // [54:35] instant_rpm, [74:55] average_rpm, zeros
  output logic [3:0]  m_axis_tuser   // [1:0] out_channel, [3:2] speed_flag
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_START = 5'b00100,
    S_CALC  = 5'b01000,
    S_HOLD  = 5'b10000
  } top_state_e;

  top_state_e state_q, state_d;

  logic [mct_pkg::PPR_W-1:0]  ppr_q;
  logic [mct_pkg::CH_W-1:0]   ch_q;
  logic [mct_pkg::TIME_W-1:0] time_q;
  logic [mct_pkg::CNT_W-1:0]  count_q;

  mct_pkg::hist_rd_t hist_rd;

  logic                       start;
  logic [mct_pkg::TIME_W-1:0] single_iv, average_iv;
  logic                       single_done, average_done;
  logic [mct_pkg::RPM_W-1:0]  instant_rpm, average_rpm;
  logic                       single_sat, average_sat;

  logic                       slot_free, load;
  logic [mct_pkg::FLAG_W-1:0] flag;

  logic                       out_valid_q;
  logic [mct_pkg::CH_W-1:0]   out_ch_q;
  logic [mct_pkg::CNT_W-1:0]  out_cnt_q;
  logic [mct_pkg::TIME_W-1:0] out_time_q;
  logic [mct_pkg::RPM_W-1:0]  out_single_q, out_average_q;
  logic [mct_pkg::FLAG_W-1:0] out_flag_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppr_q <= mct_pkg::PPR_RESET;
    end else if (cfg_valid_i) begin
      ppr_q <= cfg_data_i;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign start         = (state_q == S_START);
  assign slot_free     = !out_valid_q || m_axis_tready;
  assign load          = (state_q == S_HOLD) && slot_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = S_READ;
        end
      end
      S_READ:  state_d = S_START;
      S_START: state_d = S_CALC;
      S_CALC: begin
        if (single_done && average_done) begin
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      ch_q   <= s_axis_tuser;
      time_q <= s_axis_tdata;
    end
    if (start) begin
      count_q <= hist_rd.count;
    end
  end

  // Read in the read state, the ring is written at start once both old entries are out.
  mct_hist u_hist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ch_i    (ch_q),
    .rd_en_i (state_q == S_READ),
    .wr_en_i (start),
    .time_i  (time_q),
    .rd_o    (hist_rd)
  );

  assign single_iv  = time_q - hist_rd.last_time;
  assign average_iv = time_q - hist_rd.old_time;

  mct_rpm u_single (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .count_i    (mct_pkg::CNT_W'(1)),
    .interval_i (single_iv),
    .ppr_i      (ppr_q),
    .done_o     (single_done),
    .rpm_o      (instant_rpm),
    .sat_o      (single_sat)
  );

  mct_rpm u_average (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .count_i    (hist_rd.count),
    .interval_i (average_iv),
    .ppr_i      (ppr_q),
    .done_o     (average_done),
    .rpm_o      (average_rpm),
    .sat_o      (average_sat)
  );

  always_comb begin
    if (count_q == '0) begin
      flag = mct_pkg::FLAG_NO_EDGE;
    end else if (single_sat || average_sat) begin
      flag = mct_pkg::FLAG_SAT;
    end else begin
      flag = mct_pkg::FLAG_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_ch_q   <= ch_q;
      out_cnt_q  <= count_q;
      out_time_q <= time_q;
      out_flag_q <= flag;
      if (count_q == '0) begin
        out_single_q  <= '0;
        out_average_q <= '0;
      end else begin
        out_single_q  <= instant_rpm;
        out_average_q <= average_rpm;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_average_q, out_single_q, out_time_q, out_cnt_q};
  assign m_axis_tuser  = {out_flag_q, out_ch_q};

  // Only one edge is in flight: after a transfer the input stays closed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an edge is still in flight");

  // Both speed units are started together and must finish together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    single_done == average_done)
    else $error("speed units out of step");

  // A first edge reports no samples and zero speeds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[3:2] == mct_pkg::FLAG_NO_EDGE)
      |-> (m_axis_tdata[2:0] == '0) && (m_axis_tdata[74:35] == '0))
    else $error("no-edge result carries a speed");

  // The window never holds more edges than the ring.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= mct_pkg::CNT_W'(mct_pkg::HISTORY))
    else $error("sample count beyond history depth");

endmodule

FILE: tb/sv/multi_channel_tachometer_test.sv
// Self-checking testbench of the multi-channel tachometer, with its own speed predictor.
module multi_channel_tachometer_test;
  import mct_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam longint unsigned RPM_TOP = 64'd1048575;

  typedef struct packed {
    logic [CH_W-1:0]   channel;
    logic [CNT_W-1:0]  samples;
    logic [TIME_W-1:0] stamp;
    logic [RPM_W-1:0]  instant_rpm;
    logic [RPM_W-1:0]  average_rpm;
    logic [FLAG_W-1:0] flag;
  } speed_report_t;

  logic               clk_i;
  logic               rst_ni        = 1'b0;
  logic               cfg_valid_i   = 1'b0;
  logic               cfg_ready_o;
  logic [PPR_W-1:0]   cfg_data_i    = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [31:0]        s_axis_tdata  = '0;
  logic [1:0]         s_axis_tuser  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [79:0]        m_axis_tdata;
  logic [3:0]         m_axis_tuser;

  // Predictor state: per-channel timestamp rings and the pulses-per-revolution setting.
  logic [TIME_W-1:0]  stamp_ring [CHANNELS][HISTORY];
  int unsigned        ring_pos   [CHANNELS];
  bit                 ring_full  [CHANNELS];
  logic [PPR_W-1:0]   pulses;
  logic [TIME_W-1:0]  last_stamp [CHANNELS];

  speed_report_t      pending_reports [$];
  int                 errors      = 0;
  int                 cycles      = 0;
  bit                 idle_bursts = 1'b1;
  int                 stall_left  = 0;

  multi_channel_tachometer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // The top bit of the return value marks saturation.
  function automatic logic [RPM_W:0] rpm_of_interval(input int unsigned count,
                                                     input logic [TIME_W-1:0] interval,
                                                     input logic [PPR_W-1:0] ppr);
    longint unsigned den;
    longint unsigned num;
    longint unsigned quot;
    den = ppr * interval;
    if (den == 0) return {1'b1, RPM_W'(RPM_TOP)};
    num = USEC_PER_MIN;
    num = num * count;
    quot = num / den;
    if (quot > RPM_TOP) return {1'b1, RPM_W'(RPM_TOP)};
    return {1'b0, quot[RPM_W-1:0]};
  endfunction

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Checks each transfer with the oldest prediction; stalls at random with idle_bursts.
  always @(posedge clk_i) begin : result_check
    speed_report_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_reports.size() == 0) begin
          $error("result transfer with no edge waiting: tdata %h tuser %h",
                 m_axis_tdata, m_axis_tuser);
          errors++;
        end else begin
          want = pending_reports.pop_front();
          check_field("out_channel", want.channel, m_axis_tuser[1:0]);
          check_field("samples_used", want.samples, m_axis_tdata[2:0]);
          check_field("out_time", want.stamp, m_axis_tdata[34:3]);
          check_field("instant_rpm", want.instant_rpm, m_axis_tdata[54:35]);
          check_field("average_rpm", want.average_rpm, m_axis_tdata[74:55]);
          check_field("speed_flag", want.flag, m_axis_tuser[3:2]);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_bursts && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 7);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Sends one edge and predicts its report. tvalid is left high after the transfer so that
  // a following edge can go back to back; anything that pauses the stream lowers it.
  task automatic send_edge(input logic [CH_W-1:0] ch, input logic [TIME_W-1:0] stamp);
    speed_report_t  rep;
    int unsigned    pos;
    int unsigned    count;
    int unsigned    prev;
    int unsigned    oldest;
    logic [RPM_W:0] one;
    logic [RPM_W:0] avg;
    if (idle_bursts && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= stamp;
    s_axis_tuser  <= ch;
    do @(posedge clk_i); while (!s_axis_tready);

    pos   = ring_pos[ch];
    count = ring_full[ch] ? HISTORY : pos;
    rep.channel     = ch;
    rep.samples     = CNT_W'(count);
    rep.stamp       = stamp;
    rep.instant_rpm = '0;
    rep.average_rpm = '0;
    if (count == 0) begin
      rep.flag = FLAG_NO_EDGE;
    end else begin
      prev   = (pos + HISTORY - 1) % HISTORY;
      oldest = ring_full[ch] ? pos : 0;
      one = rpm_of_interval(1, stamp - stamp_ring[ch][prev], pulses);
      avg = rpm_of_interval(count, stamp - stamp_ring[ch][oldest], pulses);
      rep.instant_rpm = one[RPM_W-1:0];
      rep.average_rpm = avg[RPM_W-1:0];
      rep.flag = (one[RPM_W] || avg[RPM_W]) ? FLAG_SAT : FLAG_OK;
    end
    pending_reports.push_back(rep);

    stamp_ring[ch][pos] = stamp;
    pos = (pos + 1) % HISTORY;
    ring_pos[ch] = pos;
    if (pos == 0) ring_full[ch] = 1'b1;
    last_stamp[ch] = stamp;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_reports.size() != 0);
  endtask

  task automatic set_pulses(input logic [PPR_W-1:0] value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    pulses = value;
  endtask

  // Mostly plausible edge trains per channel, with some tiny or wrapping intervals
  // and some timestamps that are pure noise.
  task automatic run_random(input int n);
    logic [CH_W-1:0]   ch;
    logic [TIME_W-1:0] stamp;
    int                kind;
    for (int i = 0; i < n; i++) begin
      ch   = CH_W'($urandom_range(0, CHANNELS - 1));
      kind = $urandom_range(0, 99);
      if (kind < 70)
        stamp = last_stamp[ch] + $urandom_range(1, 1 << $urandom_range(3, 22));
      else if (kind < 80)
        stamp = last_stamp[ch] + $urandom_range(0, 3);
      else if (kind < 90)
        stamp = last_stamp[ch] + $urandom;
      else
        stamp = $urandom;
      send_edge(ch, stamp);
    end
  endtask

  task automatic test_first_edges();
    send_edge(2'd0, 32'h0000_0000);
    send_edge(2'd1, 32'hFFFF_FFFF);
    send_edge(2'd2, 32'h5555_5555);
    send_edge(2'd3, 32'hAAAA_AAAA);
  endtask

  task automatic test_short_intervals();
    send_edge(2'd0, 32'h0000_0000);   // zero interval
    send_edge(2'd0, 32'h0000_0001);   // far too fast
    send_edge(2'd1, 32'h0000_0010);   // interval across the counter wrap
    // Fill channel two beyond its history so that the ring wraps.
    for (int k = 1; k <= 6; k++) send_edge(2'd2, 32'h5555_5555 + k * 12000);
    // Just over and just under the top of the speed range.
    send_edge(2'd3, last_stamp[3] + 11);
    send_edge(2'd3, last_stamp[3] + 12);
  endtask

  task automatic test_pulse_extremes();
    set_pulses(8'd255);
    send_edge(2'd3, last_stamp[3] + 100);
    set_pulses(8'd0);
    send_edge(2'd3, last_stamp[3] + 100);
    send_edge(2'd1, last_stamp[1] + 5000);
    set_pulses(8'd1);
    send_edge(2'd0, last_stamp[0] + 60);
  endtask

  task automatic test_random_traffic();
    logic [PPR_W-1:0] setting;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: setting = 8'd255;
        1: setting = PPR_RESET;
        3: setting = 8'd1;
        default: setting = PPR_W'($urandom_range(1, 255));
      endcase
      set_pulses(setting);
      for (int chunk = 0; chunk < 3; chunk++) begin
        idle_bursts = ($urandom_range(0, 3) != 0);
        // Hold the stream back once until the block has caught up.
        if (phase == 2 && chunk == 1) wait_drained();
        run_random(60);
      end
    end
  endtask

  task automatic test_steady_stream();
    set_pulses(PPR_W'($urandom_range(1, 255)));
    idle_bursts = 1'b0;
    run_random(150);
  endtask

  initial begin
    for (int c = 0; c < CHANNELS; c++) begin
      ring_pos[c]   = 0;
      ring_full[c]  = 1'b0;
      last_stamp[c] = $urandom;
    end
    pulses = PPR_RESET;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_first_edges();
    test_short_intervals();
    test_pulse_extremes();
    test_random_traffic();
    test_steady_stream();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
